// ----- rtl/core/ufqs_pkg.sv -----
// ----------------------------------------------------------------------------
// ufqs_pkg
// Shared types, character codes and helpers for the form query splitter.
// ----------------------------------------------------------------------------
package ufqs_pkg;

  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharQmark = 8'h3F;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharAmp   = 8'h26;

  localparam logic [7:0] PairLimitReset = 8'd32;

  typedef enum logic [2:0] {
    KIND_NAME    = 3'd0,
    KIND_VALUE   = 3'd1,
    KIND_PAIR    = 3'd2,
    KIND_DISCARD = 3'd3,
    KIND_END     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_e;

  typedef enum logic [1:0] {
    MODE_NAME_EMPTY = 2'd0,
    MODE_VALUE      = 2'd1,
    MODE_IGNORE     = 2'd2,
    MODE_NAME_BUSY  = 2'd3
  } mode_e;

  // One decoded byte handed from the percent decoder to the splitter.
  typedef struct packed {
    logic       have;
    logic [7:0] data;
  } dec_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] idx;
    logic       done;
  } result_t;

  // Up to two results produced by one input item, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } split_t;

  // Bit 4 flags a hex digit, bits 3..0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/ufqs_pct_decode.sv -----
// ----------------------------------------------------------------------------
// ufqs_pct_decode
// Percent and plus decoding of the raw byte stream, with escape state.
// ----------------------------------------------------------------------------
module ufqs_pct_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    raw_byte_i,
  input  logic          final_byte_i,
  output ufqs_pkg::dec_t dec_o
);

  ufqs_pkg::esc_e esc_q, esc_d;
  logic [4:0]     first_digit_q, first_digit_d;
  logic [4:0]     hv;

  always_comb begin
    hv            = ufqs_pkg::hex_digit(raw_byte_i);
    dec_o         = '0;
    esc_d         = esc_q;
    first_digit_d = first_digit_q;
    case (esc_q)
      ufqs_pkg::ESC_PCT: begin
        if (final_byte_i) begin
          // The escape is cut short: a lone hex digit yields its own value as a byte.
          dec_o.data = hv[4] ? {4'd0, hv[3:0]} : ufqs_pkg::CharQmark;
          dec_o.have = 1'b1;
          esc_d      = ufqs_pkg::ESC_NONE;
        end else begin
          first_digit_d = hv[4] ? hv : 5'd0;
          esc_d         = ufqs_pkg::ESC_DIGIT;
        end
      end
      ufqs_pkg::ESC_DIGIT: begin
        if (first_digit_q[4]) begin
          dec_o.data = hv[4] ? {first_digit_q[3:0], hv[3:0]} : {4'd0, first_digit_q[3:0]};
        end else begin
          dec_o.data = ufqs_pkg::CharQmark;
        end
        dec_o.have = 1'b1;
        esc_d      = ufqs_pkg::ESC_NONE;
      end
      default: begin
        esc_d = ufqs_pkg::ESC_NONE;
        if (raw_byte_i == ufqs_pkg::CharPct) begin
          if (final_byte_i) begin
            dec_o.data = ufqs_pkg::CharQmark;
            dec_o.have = 1'b1;
          end else begin
            esc_d = ufqs_pkg::ESC_PCT;
          end
        end else begin
          dec_o.data = (raw_byte_i == ufqs_pkg::CharPlus) ? ufqs_pkg::CharSpace : raw_byte_i;
          dec_o.have = 1'b1;
        end
      end
    endcase
    if (final_byte_i) begin
      esc_d         = ufqs_pkg::ESC_NONE;
      first_digit_d = 5'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q         <= ufqs_pkg::ESC_NONE;
      first_digit_q <= 5'd0;
    end else if (accept_i) begin
      esc_q         <= esc_d;
      first_digit_q <= first_digit_d;
    end
  end

endmodule

// ----- rtl/core/ufqs_splitter.sv -----
// ----------------------------------------------------------------------------
// ufqs_splitter
// Splits decoded bytes into name and value results and tracks the pair count.
// ----------------------------------------------------------------------------
module ufqs_splitter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  ufqs_pkg::dec_t  dec_i,
  input  logic            final_byte_i,
  input  logic [7:0]      pair_limit_i,
  output ufqs_pkg::split_t split_o
);

  ufqs_pkg::mode_e   mode_q, mode_d, mode_mid;
  logic [7:0]        pairs_q, pairs_d, pairs_mid;
  ufqs_pkg::result_t sres, fres;
  logic              s_emit;
  logic              at_limit;

  always_comb begin
    mode_mid  = mode_q;
    pairs_mid = pairs_q;
    sres      = '0;
    s_emit    = 1'b0;
    at_limit  = (pairs_q >= pair_limit_i);

    if (dec_i.have) begin
      case (mode_q)
        ufqs_pkg::MODE_IGNORE: begin
          mode_mid = ufqs_pkg::MODE_IGNORE;
        end
        ufqs_pkg::MODE_VALUE: begin
          s_emit   = 1'b1;
          sres.idx = pairs_q - 8'd1;
          if (dec_i.data == ufqs_pkg::CharAmp) begin
            sres.kind = ufqs_pkg::KIND_PAIR;
            mode_mid  = at_limit ? ufqs_pkg::MODE_IGNORE : ufqs_pkg::MODE_NAME_EMPTY;
          end else begin
            sres.kind = ufqs_pkg::KIND_VALUE;
            sres.data = dec_i.data;
          end
        end
        default: begin
          sres.idx = pairs_q;
          if (dec_i.data == ufqs_pkg::CharEq) begin
            if (at_limit) begin
              s_emit    = 1'b1;
              sres.kind = ufqs_pkg::KIND_DISCARD;
              mode_mid  = ufqs_pkg::MODE_IGNORE;
            end else begin
              pairs_mid = pairs_q + 8'd1;
              mode_mid  = ufqs_pkg::MODE_VALUE;
            end
          end else if (dec_i.data == ufqs_pkg::CharAmp) begin
            s_emit    = (mode_q == ufqs_pkg::MODE_NAME_BUSY);
            sres.kind = ufqs_pkg::KIND_DISCARD;
            mode_mid  = ufqs_pkg::MODE_NAME_EMPTY;
          end else begin
            s_emit    = 1'b1;
            sres.kind = ufqs_pkg::KIND_NAME;
            sres.data = dec_i.data;
            mode_mid  = ufqs_pkg::MODE_NAME_BUSY;
          end
        end
      endcase
    end

    // The closing result of a query sees the state left by its last byte.
    fres      = '0;
    fres.done = 1'b1;
    case (mode_mid)
      ufqs_pkg::MODE_VALUE: begin
        fres.kind = ufqs_pkg::KIND_PAIR;
        fres.idx  = pairs_mid - 8'd1;
      end
      ufqs_pkg::MODE_NAME_BUSY: begin
        fres.kind = ufqs_pkg::KIND_DISCARD;
        fres.idx  = pairs_mid;
      end
      default: begin
        fres.kind = ufqs_pkg::KIND_END;
      end
    endcase

    split_o = '0;
    if (s_emit) begin
      split_o.first  = sres;
      split_o.second = fres;
    end else begin
      split_o.first  = fres;
    end
    split_o.count = {1'b0, s_emit} + {1'b0, final_byte_i};

    if (final_byte_i) begin
      mode_d  = ufqs_pkg::MODE_NAME_EMPTY;
      pairs_d = 8'd0;
    end else begin
      mode_d  = mode_mid;
      pairs_d = pairs_mid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ufqs_pkg::MODE_NAME_EMPTY;
      pairs_q <= 8'd0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      pairs_q <= pairs_d;
    end
  end

endmodule

// ----- rtl/core/ufqs_result_fifo.sv -----
// ----------------------------------------------------------------------------
// ufqs_result_fifo
// Small result queue: takes up to two items a cycle, delivers one a cycle when popped.
// ----------------------------------------------------------------------------
module ufqs_result_fifo #(
  parameter int Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_n_i,
  input  ufqs_pkg::result_t push0_i,
  input  ufqs_pkg::result_t push1_i,
  input  logic              pop_i,
  output ufqs_pkg::result_t head_o,
  output logic [$clog2(Depth+1)-1:0] level_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  ufqs_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q, wr_ptr_nxt;
  logic [CntW-1:0]   count_q, count_d;

  // Depth must be a power of two so the pointers wrap by themselves; this block does not check it.
  assign wr_ptr_nxt = wr_ptr_q + PtrW'(1);
  assign count_d    = count_q + CntW'(push_n_i) - CntW'(pop_i);
  assign head_o     = mem_q[rd_ptr_q];
  assign level_o    = count_q;

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n_i);
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

// ----- rtl/core/url_form_query_splitter_core.sv -----
// ----------------------------------------------------------------------------
// url_form_query_splitter_core
// Percent-decodes a form query a byte at a time and splits it into pairs.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  cfg      in         cfg_we_i                  cfg_wdata_i (pair limit)
//  in       in         in_valid_i / in_stall_o   raw_byte_i, final_byte_i
//  out      out        out_valid_o / out_stall_i kind_o, decoded_byte_o,
//                                                pair_index_o, query_done_o
//
// One byte is taken per cycle unless in_stall_o is set; its results are ready
// in the next cycle. A byte yields zero, one or two results, and the output port
// delivers one per cycle unless out_stall_i is set, so two results leave in turn.
// in_stall_o rises when the result queue has fewer than two free entries.
// Reset clears the decoder, the splitter and the queue, and sets the limit to 32.
// FifoDepth must be a power of two, at least 2.
module url_form_query_splitter_core #(
  parameter int FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] raw_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] decoded_byte_o,
  output logic [7:0] pair_index_o,
  output logic       query_done_o
);

  localparam int CntW = $clog2(FifoDepth + 1);

  logic                    in_accept;
  logic                    out_pop;
  logic [7:0]              pair_limit_q;
  ufqs_pkg::dec_t          dec;
  ufqs_pkg::split_t        split;
  ufqs_pkg::result_t       head;
  logic [1:0]              push_n;
  logic [CntW-1:0]         fifo_level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_limit_q <= ufqs_pkg::PairLimitReset;
    end else if (cfg_we_i) begin
      pair_limit_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = (fifo_level > CntW'(FifoDepth - 2));
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_valid_o = (fifo_level != '0);
  assign out_pop    = out_valid_o && !out_stall_i;
  assign push_n     = in_accept ? split.count : 2'd0;

  ufqs_pct_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .raw_byte_i   (raw_byte_i),
    .final_byte_i (final_byte_i),
    .dec_o        (dec)
  );

  ufqs_splitter u_splitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .dec_i        (dec),
    .final_byte_i (final_byte_i),
    .pair_limit_i (pair_limit_q),
    .split_o      (split)
  );

  ufqs_result_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (split.first),
    .push1_i  (split.second),
    .pop_i    (out_pop),
    .head_o   (head),
    .level_o  (fifo_level)
  );

  assign kind_o         = head.kind;
  assign decoded_byte_o = head.data;
  assign pair_index_o   = head.idx;
  assign query_done_o   = head.done;

  // A final byte always produces at least the closing result.
  a_final_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && final_byte_i) |-> (split.count != 2'd0))
    else $error("final byte produced no result");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_level <= CntW'(FifoDepth))
    else $error("result queue overflow");

  a_final_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && final_byte_i) |=> out_valid_o)
    else $error("closing result not presented after final byte");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o) |=> (fifo_level <= $past(fifo_level)))
    else $error("queue grew while input was stalled");

endmodule

// ----- verif/url_form_query_splitter_core_tb.sv -----
// ----------------------------------------------------------------------------
// url_form_query_splitter_core_tb
// Sends raw form query bytes into the splitter core. A predictor written in
// the testbench computes the expected results of each byte. Every delivered
// result is checked field by field against the oldest expected one. Both
// handshakes are throttled at random, and the run steps through several pair
// limit settings.
// ----------------------------------------------------------------------------
module url_form_query_splitter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 800000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] raw_byte_i;
  logic       final_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] kind_o;
  logic [7:0] decoded_byte_o;
  logic [7:0] pair_index_o;
  logic       query_done_o;

  url_form_query_splitter_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .raw_byte_i     (raw_byte_i),
    .final_byte_i   (final_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .decoded_byte_o (decoded_byte_o),
    .pair_index_o   (pair_index_o),
    .query_done_o   (query_done_o)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state, mirroring the decoder and the splitter.
  logic [7:0]       pair_limit   = ufqs_pkg::PairLimitReset;
  ufqs_pkg::esc_e   esc_state    = ufqs_pkg::ESC_NONE;
  logic [4:0]       first_nibble = 5'd0;
  ufqs_pkg::mode_e  field_mode   = ufqs_pkg::MODE_NAME_EMPTY;
  logic [7:0]       pair_total   = 8'd0;

  ufqs_pkg::result_t pending_q[$];
  logic [7:0]        query_buf[$];

  int  errors        = 0;
  int  items_sent    = 0;
  int  results_seen  = 0;
  int  queries_sent  = 0;
  int  limit_writes  = 0;
  int  cycles        = 0;
  int  hold_left     = 0;
  bit  tx_gaps       = 1'b0;
  bit  rx_gaps       = 1'b0;

  // ---------------------------------------------------------------- predictor

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= "0" && c <= "9") begin
      v = c - "0";
      return {1'b1, v[3:0]};
    end
    if (c >= "a" && c <= "f") begin
      v = c - "a" + 8'd10;
      return {1'b1, v[3:0]};
    end
    if (c >= "A" && c <= "F") begin
      v = c - "A" + 8'd10;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic void expect_result(input ufqs_pkg::kind_e k, input logic [7:0] data,
                                        input logic [7:0] idx, input logic done);
    ufqs_pkg::result_t r;
    r.kind = k;
    r.data = data;
    r.idx  = idx;
    r.done = done;
    pending_q.push_back(r);
  endfunction

  function automatic void split_decoded(input logic [7:0] d);
    case (field_mode)
      ufqs_pkg::MODE_IGNORE: begin
      end
      ufqs_pkg::MODE_VALUE: begin
        if (d == ufqs_pkg::CharAmp) begin
          expect_result(ufqs_pkg::KIND_PAIR, 8'd0, pair_total - 8'd1, 1'b0);
          field_mode = (pair_total >= pair_limit) ? ufqs_pkg::MODE_IGNORE
                                                  : ufqs_pkg::MODE_NAME_EMPTY;
        end else begin
          expect_result(ufqs_pkg::KIND_VALUE, d, pair_total - 8'd1, 1'b0);
        end
      end
      default: begin
        if (d == ufqs_pkg::CharEq) begin
          if (pair_total >= pair_limit) begin
            expect_result(ufqs_pkg::KIND_DISCARD, 8'd0, pair_total, 1'b0);
            field_mode = ufqs_pkg::MODE_IGNORE;
          end else begin
            pair_total = pair_total + 8'd1;
            field_mode = ufqs_pkg::MODE_VALUE;
          end
        end else if (d == ufqs_pkg::CharAmp) begin
          if (field_mode == ufqs_pkg::MODE_NAME_BUSY) begin
            expect_result(ufqs_pkg::KIND_DISCARD, 8'd0, pair_total, 1'b0);
          end
          field_mode = ufqs_pkg::MODE_NAME_EMPTY;
        end else begin
          expect_result(ufqs_pkg::KIND_NAME, d, pair_total, 1'b0);
          field_mode = ufqs_pkg::MODE_NAME_BUSY;
        end
      end
    endcase
  endfunction

  function automatic void predict_byte(input logic [7:0] raw, input logic fin);
    logic [4:0] h;
    logic       have;
    logic [7:0] d;
    h    = hex_nibble(raw);
    have = 1'b0;
    d    = 8'd0;
    case (esc_state)
      ufqs_pkg::ESC_PCT: begin
        // An escape cut short by the final byte is not read past.
        if (fin) begin
          d         = h[4] ? {4'h0, h[3:0]} : ufqs_pkg::CharQmark;
          have      = 1'b1;
          esc_state = ufqs_pkg::ESC_NONE;
        end else begin
          first_nibble = h;
          esc_state    = ufqs_pkg::ESC_DIGIT;
        end
      end
      ufqs_pkg::ESC_DIGIT: begin
        if (first_nibble[4]) begin
          d = h[4] ? {first_nibble[3:0], h[3:0]} : {4'h0, first_nibble[3:0]};
        end else begin
          d = ufqs_pkg::CharQmark;
        end
        have      = 1'b1;
        esc_state = ufqs_pkg::ESC_NONE;
      end
      default: begin
        esc_state = ufqs_pkg::ESC_NONE;
        if (raw == ufqs_pkg::CharPct) begin
          if (fin) begin
            d    = ufqs_pkg::CharQmark;
            have = 1'b1;
          end else begin
            esc_state = ufqs_pkg::ESC_PCT;
          end
        end else begin
          d    = (raw == ufqs_pkg::CharPlus) ? ufqs_pkg::CharSpace : raw;
          have = 1'b1;
        end
      end
    endcase
    if (have) split_decoded(d);
    if (fin) begin
      case (field_mode)
        ufqs_pkg::MODE_VALUE:
          expect_result(ufqs_pkg::KIND_PAIR, 8'd0, pair_total - 8'd1, 1'b1);
        ufqs_pkg::MODE_NAME_BUSY:
          expect_result(ufqs_pkg::KIND_DISCARD, 8'd0, pair_total, 1'b1);
        default:
          expect_result(ufqs_pkg::KIND_END, 8'd0, 8'd0, 1'b1);
      endcase
      esc_state    = ufqs_pkg::ESC_NONE;
      first_nibble = 5'd0;
      field_mode   = ufqs_pkg::MODE_NAME_EMPTY;
      pair_total   = 8'd0;
    end
  endfunction

  // ------------------------------------------------------------ result checks

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    ufqs_pkg::result_t r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch("result with nothing expected, kind", int'(kind_o), 0);
      end else begin
        r = pending_q.pop_front();
        if (kind_o !== r.kind) report_mismatch("kind", int'(kind_o), int'(r.kind));
        if (decoded_byte_o !== r.data) begin
          report_mismatch("decoded_byte", int'(decoded_byte_o), int'(r.data));
        end
        if (pair_index_o !== r.idx) begin
          report_mismatch("pair_index", int'(pair_index_o), int'(r.idx));
        end
        if (query_done_o !== r.done) begin
          report_mismatch("query_done", int'(query_done_o), int'(r.done));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, pending_q.size());
      $display("url_form_query_splitter_core: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------- handshakes

  function automatic int idle_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Receiver: a requested hold-off first, then random stalls when enabled.
  initial begin : receiver
    int stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
        if (rx_gaps && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  task automatic send_byte(input logic [7:0] raw, input logic fin);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    raw_byte_i   = raw;
    final_byte_i = fin;
    do @(posedge clk_i); while (in_stall_o);
    predict_byte(raw, fin);
    items_sent++;
  endtask

  // Lowers valid and waits until every expected result has been delivered.
  task automatic wait_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [7:0] value);
    wait_results();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    pair_limit = value;
    limit_writes++;
  endtask

  task automatic send_text(input string s, input bit fin_last);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], fin_last && (i == s.len() - 1));
    end
    if (fin_last) queries_sent++;
  endtask

  // Sends the built query with the final flag on its last byte. When pause_at
  // is positive, the sender stops there until all results are in.
  task automatic send_query(input int pause_at);
    if (query_buf.size() == 0) query_buf.push_back(8'(32'h61 + $urandom_range(0, 25)));
    for (int i = 0; i < query_buf.size(); i++) begin
      if (pause_at > 0 && i == pause_at) wait_results();
      send_byte(query_buf[i], i == query_buf.size() - 1);
    end
    query_buf.delete();
    queries_sent++;
  endtask

  // ------------------------------------------------------------ query builder

  function automatic logic [7:0] hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  function automatic void push_field_byte(input bit in_value);
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4, 5: query_buf.push_back(8'(32'h61 + $urandom_range(0, 25)));
      6: query_buf.push_back(ufqs_pkg::CharPlus);
      7, 8: begin
        // Mostly well-formed escapes, some with broken digits.
        query_buf.push_back(ufqs_pkg::CharPct);
        query_buf.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                        : hex_char());
        query_buf.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                        : hex_char());
      end
      9: query_buf.push_back(in_value ? ufqs_pkg::CharEq : hex_char());
      10: query_buf.push_back(8'($urandom_range(0, 255)));
      default: query_buf.push_back(8'(32'h30 + $urandom_range(0, 9)));
    endcase
  endfunction

  function automatic void build_query(input int max_pairs, input int max_len);
    int npairs;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 5))
          0: query_buf.push_back(ufqs_pkg::CharEq);
          1: query_buf.push_back(ufqs_pkg::CharAmp);
          2: query_buf.push_back(ufqs_pkg::CharPct);
          default: query_buf.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      return;
    end
    npairs = $urandom_range(0, max_pairs);
    for (int p = 0; p < npairs; p++) begin
      repeat ($urandom_range(0, max_len)) push_field_byte(1'b0);
      if ($urandom_range(0, 7) != 0) begin
        query_buf.push_back(ufqs_pkg::CharEq);
        repeat ($urandom_range(0, max_len)) push_field_byte(1'b1);
      end
      if (p != npairs - 1 || $urandom_range(0, 3) == 0) begin
        query_buf.push_back(ufqs_pkg::CharAmp);
      end
      if ($urandom_range(0, 15) == 0) query_buf.push_back(ufqs_pkg::CharAmp);
    end
  endfunction

  // -------------------------------------------------------------------- tests

  task automatic test_decode_cases();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    // Plus, full escape, one-digit escape, non-hex escape, second '=' in a
    // value, a name without '=', an empty name, and a '%' as the final byte.
    send_text("a+%41=%fg%zZ=&x&&%FF%", 1'b1);
    send_text("%7", 1'b1);
    send_byte(ufqs_pkg::CharPct, 1'b0);
    send_byte(8'h00, 1'b1);
    queries_sent++;
    send_text("&", 1'b1);
    send_byte(8'hFF, 1'b1);
    queries_sent++;
  endtask

  task automatic test_random_default_limit();
    int stop_at;
    stop_at = items_sent + 350;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    while (items_sent < stop_at) begin
      build_query(($urandom_range(0, 3) == 0) ? 40 : 6, ($urandom_range(0, 1) == 0) ? 1 : 4);
      send_query(0);
    end
  endtask

  task automatic test_limit_extremes();
    set_limit(8'd1);
    send_text("k=v=w&q=r", 1'b1);
    send_text("n=", 1'b1);
    set_limit(8'd255);
    send_text("a=b&c=d&", 1'b0);
    // Limit lowered to the pair count already reached in the middle of a query.
    set_limit(8'd2);
    send_text("e=f&g", 1'b1);
    set_limit(8'd255);
    // Long query without idling on either side, running the pair count up to
    // the limit of 255 and past it.
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    repeat (258) begin
      query_buf.push_back(ufqs_pkg::CharEq);
      if ($urandom_range(0, 7) == 0) push_field_byte(1'b1);
      query_buf.push_back(ufqs_pkg::CharAmp);
    end
    send_query(0);
  endtask

  task automatic test_random_limits();
    logic [7:0] lim;
    int stop_at;
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: lim = 8'd1;
        1: lim = 8'd2;
        2: lim = 8'd255;
        3: lim = 8'($urandom_range(1, 8));
        default: lim = 8'($urandom_range(1, 255));
      endcase
      set_limit(lim);
      tx_gaps = (k != 1);
      rx_gaps = (k != 4);
      stop_at = items_sent + 70;
      while (items_sent < stop_at) begin
        build_query(6, 4);
        send_query(0);
      end
    end
  endtask

  task automatic test_backpressure();
    set_limit(8'd32);
    tx_gaps   = 1'b0;
    rx_gaps   = 1'b1;
    hold_left = 100;
    build_query(12, 3);
    while (query_buf.size() < 30) push_field_byte(1'b1);
    send_query(0);
    // The sender stops mid-query until every result is in, then resumes.
    tx_gaps = 1'b1;
    build_query(8, 3);
    while (query_buf.size() < 10) push_field_byte(1'b0);
    send_query(query_buf.size() / 2);
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 8'd0;
    in_valid_i   = 1'b0;
    raw_byte_i   = 8'd0;
    final_byte_i = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_decode_cases();
    test_random_default_limit();
    test_limit_extremes();
    test_random_limits();
    test_backpressure();
    wait_results();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d query bytes in %0d queries and checked %0d results.",
             items_sent, queries_sent, results_seen);
    $display("Covered %0d pair limit settings, long receiver hold-offs and sender pauses.",
             limit_writes + 1);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("url_form_query_splitter_core: match");
    end else begin
      $display("url_form_query_splitter_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ufqs_pkg.sv
rtl/core/ufqs_pct_decode.sv
rtl/core/ufqs_splitter.sv
rtl/core/ufqs_result_fifo.sv
rtl/core/url_form_query_splitter_core.sv
verif/url_form_query_splitter_core_tb.sv
